>>> hw/rtl/positional_ordered_list_engine_defines.svh
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_defines.svh
// assertion macros used by the checker of the list engine
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define POLE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define POLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

>>> hw/rtl/pole_pkg.sv
// ----------------------------------------------------------------------------
// pole_pkg
// types and codes shared by the positional ordered list engine
// ----------------------------------------------------------------------------
package pole_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_LAST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_POS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_VAL  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP     = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // request beat
    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } pole_req_t;

    // response beat
    typedef struct packed {
        logic signed [VALUE_W-1:0]  entry;
        logic [STATUS_W-1:0]        status;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } pole_rsp_t;

    // walking pointer updates
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LEN,
        PTR_ZERO,
        PTR_ONE,
        PTR_DEL,
        PTR_CHK,
        PTR_INC,
        PTR_DEC
    } pole_ptr_op_t;

    // entry ram read address select
    typedef enum logic [2:0] {
        RD_NONE,
        RD_PTR,
        RD_PTR_DN,
        RD_PTR_UP,
        RD_ZERO
    } pole_rd_op_t;

    // controller to datapath
    typedef struct packed {
        logic                   latch;
        pole_ptr_op_t           ptr_op;
        pole_rd_op_t            rd_op;
        logic                   move;
        logic                   place;
        logic                   len_inc;
        logic                   len_dec;
        logic                   chk_set;
        logic                   set_st;
        logic [STATUS_W-1:0]    st;
        logic                   out_load;
        logic                   out_dump;
    } pole_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               empty;
        logic               full;
        logic               pos_past;
        logic               ptr_eq_ins;
        logic               ptr_last;
        logic               ptr_eq_len;
        logic               wr_pend;
        logic               match;
        logic               out_free;
    } pole_stat_t;

endpackage

>>> hw/rtl/pole_ram.sv
// ----------------------------------------------------------------------------
// pole_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/pole_dp.sv
// ----------------------------------------------------------------------------
// pole_dp
// datapath: entry ram, length, walking pointer, move and compare pipes,
// response register
// ----------------------------------------------------------------------------
module pole_dp import pole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  pole_req_t  req,
    input  pole_cmd_t  cmd,
    output pole_stat_t stat,
    input  logic       rsp_ready,
    output logic       rsp_valid,
    output pole_rsp_t  rsp
);

    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (LW > POS_W) ? LW : POS_W;

    pole_req_t           cmd_reg;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       ptr_reg, ptr_next;
    logic [LW-1:0]       chk_idx_reg;
    logic                chk_pend_reg;
    logic                wr_pend_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                out_valid_reg, out_valid_next;
    pole_rsp_t           out_reg;

    logic [POS_W-1:0]    pos_eff;
    logic                pos_past;
    logic [LW-1:0]       ins_tgt;
    logic [LW-1:0]       del_tgt;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [VALUE_W-1:0]  rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                out_free;

    // position zero counts as one
    assign pos_eff  = (cmd_reg.position == '0) ? POS_W'(1) : cmd_reg.position;
    assign pos_past = CMPW'(pos_eff) > CMPW'(len_reg);

    // target slots for insert and delete
    assign ins_tgt = ((cmd_reg.mode == MODE_APPEND) || pos_past) ?
                     len_reg : LW'(pos_eff - POS_W'(1));
    assign del_tgt = pos_past ? (len_reg - LW'(1)) : LW'(pos_eff - POS_W'(1));

    // pointer update
    always_comb
    begin
        case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_LEN:  ptr_next = len_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_ONE:  ptr_next = LW'(1);
            PTR_DEL:  ptr_next = del_tgt;
            PTR_CHK:  ptr_next = chk_idx_reg;
            PTR_INC:  ptr_next = ptr_reg + LW'(1);
            PTR_DEC:  ptr_next = ptr_reg - LW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    // read address select
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = AW'(ptr_reg);
        case (cmd.rd_op)
            RD_NONE:   rd_en   = 1'b0;
            RD_PTR:    rd_addr = AW'(ptr_reg);
            RD_PTR_DN: rd_addr = AW'(ptr_reg - LW'(1));
            RD_PTR_UP: rd_addr = AW'(ptr_reg + LW'(1));
            RD_ZERO:   rd_addr = '0;
            default:   rd_en   = 1'b0;
        endcase
    end

    // write port: pending move has the port, else the new value
    assign wr_en   = wr_pend_reg || cmd.place;
    assign wr_addr = wr_pend_reg ? wr_addr_reg : AW'(ptr_reg);
    assign wr_data = wr_pend_reg ? rd_data : VALUE_W'(cmd_reg.value);

    pole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // length
    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_inc)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (cmd.len_dec)
        begin
            len_next = len_reg - LW'(1);
        end
    end

    // response register frees when the beat is taken
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            chk_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            wr_pend_reg   <= cmd.move;
            chk_pend_reg  <= cmd.chk_set;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.latch)
        begin
            cmd_reg <= req;
        end
        if (cmd.move)
        begin
            wr_addr_reg <= AW'(ptr_reg);
        end
        if (cmd.chk_set)
        begin
            chk_idx_reg <= ptr_reg;
        end
        if (cmd.set_st)
        begin
            st_reg <= cmd.st;
        end
        if (cmd.out_load)
        begin
            out_reg.entry  <= cmd.out_dump ? $signed(rd_data) : '0;
            out_reg.status <= st_reg;
            out_reg.count  <= COUNT_W'(len_reg);
            out_reg.last   <= cmd.out_dump ? (ptr_reg == len_reg) : 1'b1;
        end
    end

    // status to controller
    always_comb
    begin
        stat.mode       = cmd_reg.mode;
        stat.empty      = (len_reg == '0);
        stat.full       = (len_reg == LW'(CAPACITY));
        stat.pos_past   = pos_past;
        stat.ptr_eq_ins = (ptr_reg == ins_tgt);
        stat.ptr_last   = ((ptr_reg + LW'(1)) == len_reg);
        stat.ptr_eq_len = (ptr_reg == len_reg);
        stat.wr_pend    = wr_pend_reg;
        stat.match      = chk_pend_reg && (rd_data == VALUE_W'(cmd_reg.value));
        stat.out_free   = out_free;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> hw/rtl/pole_ctrl.sv
// ----------------------------------------------------------------------------
// pole_ctrl
// controller: decodes one command and steps the datapath through shifts,
// searches and dumps
// ----------------------------------------------------------------------------
module pole_ctrl import pole_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  pole_stat_t stat,
    output pole_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEARCH,
        S_DUMP,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.latch    = 1'b0;
        cmd.ptr_op   = PTR_HOLD;
        cmd.rd_op    = RD_NONE;
        cmd.move     = 1'b0;
        cmd.place    = 1'b0;
        cmd.len_inc  = 1'b0;
        cmd.len_dec  = 1'b0;
        cmd.chk_set  = 1'b0;
        cmd.set_st   = 1'b0;
        cmd.st       = ST_OK;
        cmd.out_load = 1'b0;
        cmd.out_dump = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.set_st = 1'b1;
                case (stat.mode)
                    MODE_APPEND, MODE_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.st     = ST_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.st     = ((stat.mode == MODE_INSERT) && stat.pos_past) ?
                                         ST_RANGE : ST_OK;
                            cmd.ptr_op = PTR_LEN;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    MODE_DEL_LAST:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.len_dec = 1'b1;
                        end
                        state_next = S_RESULT;
                    end
                    MODE_DEL_POS:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st     = ST_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.st     = stat.pos_past ? ST_RANGE : ST_OK;
                            cmd.ptr_op = PTR_DEL;
                            state_next = S_SHIFT_DN;
                        end
                    end
                    MODE_DEL_VAL:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st     = ST_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_SEARCH;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st     = ST_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.rd_op  = RD_ZERO;
                            cmd.ptr_op = PTR_ONE;
                            state_next = S_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            // move entries up one slot from the tail, then drop in the value
            S_SHIFT_UP:
            begin
                if (!stat.ptr_eq_ins)
                begin
                    cmd.rd_op  = RD_PTR_DN;
                    cmd.move   = 1'b1;
                    cmd.ptr_op = PTR_DEC;
                end
                else if (!stat.wr_pend)
                begin
                    cmd.place   = 1'b1;
                    cmd.len_inc = 1'b1;
                    state_next  = S_RESULT;
                end
            end

            // move entries down one slot toward the gap, then shrink
            S_SHIFT_DN:
            begin
                if (!stat.ptr_last)
                begin
                    cmd.rd_op  = RD_PTR_UP;
                    cmd.move   = 1'b1;
                    cmd.ptr_op = PTR_INC;
                end
                else if (!stat.wr_pend)
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = S_RESULT;
                end
            end

            // read one entry a cycle, compare it in the next cycle
            S_SEARCH:
            begin
                if (stat.match)
                begin
                    cmd.ptr_op = PTR_CHK;
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_OK;
                    state_next = S_SHIFT_DN;
                end
                else if (stat.ptr_eq_len)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NOTFOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.rd_op   = RD_PTR;
                    cmd.ptr_op  = PTR_INC;
                    cmd.chk_set = 1'b1;
                end
            end

            // emit one entry per free response slot, fetch the next
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_dump = 1'b1;
                    if (stat.ptr_eq_len)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_op  = RD_PTR;
                        cmd.ptr_op = PTR_INC;
                    end
                end
            end

            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/positional_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_engine
// ordered list of up to CAPACITY signed entries with append, positional insert
// and delete, delete of the last entry, delete by value and dump
//
//   channel | signals                   | beat
//   --------+---------------------------+-------------------------------------
//   request | req_valid, req_ready, req | one command: mode, value, position
//   response| rsp_valid, rsp_ready, rsp | entry, status, count, last flag
//
// one command at a time: accept, decode, the command's steps, response load
// insert at slot k moves the entries from slot k up one slot, from the tail,
// then drains the last move when anything moved and places the value; delete
// at slot k moves the entries above it down a slot, drains alike and shrinks
// delete by value scans from slot zero, then deletes at the first match;
// a dump replaces the response load with one entry per cycle unless stalled
// reset empties the list at once; ram contents are never cleared
// a stalled response holds the dump walk; req_ready is low until the
// command's last beat sits in the response register
// ----------------------------------------------------------------------------
module positional_ordered_list_engine import pole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  pole_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output pole_rsp_t rsp
);

    pole_cmd_t  cmd;
    pole_stat_t stat;

    // sequencer
    pole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and response
    pole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> hw/rtl/pole_checker.sv
// ----------------------------------------------------------------------------
// pole_checker
// port level checks of the list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "positional_ordered_list_engine_defines.svh"

module pole_checker import pole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input pole_req_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input pole_rsp_t rsp
);

    // a stalled response beat holds
    `POLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // no new command while a dump still has beats to deliver
    `POLE_ASSERT_IMPLY(a_dump_blocks, rsp_valid && !rsp.last, !req_ready)

    // empty status only ever reports an empty list
    `POLE_ASSERT_IMPLY(a_empty_count, rsp_valid && (rsp.status == ST_EMPTY), rsp.count == '0)

    // full status only with the list at capacity
    `POLE_ASSERT_IMPLY(a_full_count, rsp_valid && (rsp.status == ST_FULL),
        rsp.count == COUNT_W'(CAPACITY))

endmodule

bind positional_ordered_list_engine pole_checker #(
    .CAPACITY (CAPACITY)
) u_pole_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
